// File: rtl/core/tckde_pkg.sv
`default_nettype none
package tckde_pkg;
  localparam int FRAC_BITS = 16;
  localparam logic [16:0] ONE = 17'd65536;
  localparam logic [16:0] HALF = 17'd32768;
  localparam logic [16:0] EPS = 17'd655;
  localparam logic [19:0] VAR_MAX = 20'hFFFFF;
  localparam logic [17:0] DWELL_MAX = 18'd255744;
  localparam logic [16:0] OCC_RESET = 17'd39322;

  localparam logic [2:0] REG_NOISE = 3'd0;
  localparam logic [2:0] REG_BASE = 3'd1;
  localparam logic [2:0] REG_JAM = 3'd2;
  localparam logic [2:0] REG_PEN = 3'd3;
  localparam logic [2:0] REG_CRIT = 3'd4;

  localparam logic [1:0] CAT_NONE = 2'd0;
  localparam logic [1:0] CAT_MECH = 2'd1;
  localparam logic [1:0] CAT_LABOR = 2'd2;
  localparam logic [1:0] CAT_OCC = 2'd3;

  // Divider request: dividend up to 48 bits, divisor up to 21 bits.
  typedef struct packed {
    logic        start;
    logic [47:0] num;
    logic [20:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

// File: rtl/core/tckde_div.sv
`default_nettype none
// Restoring radix-2 divider producing a 48-bit quotient, one quotient bit per cycle.
module tckde_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tckde_pkg::div_req_t req,
  output tckde_pkg::div_rsp_t    rsp
);
  logic [47:0] quo_r, quo_nxt;
  logic [20:0] rem_r, rem_nxt;
  logic [20:0] den_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [21:0] trial;
  logic [22:0] diff;

  always_comb begin
    trial = {rem_r, quo_r[47]};
    diff = {1'b0, trial} - {2'b0, den_r};
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (busy_r) begin
      if (!diff[22]) begin
        rem_nxt = diff[20:0];
        quo_nxt = {quo_r[46:0], 1'b1};
      end else begin
        rem_nxt = trial[20:0];
        quo_nxt = {quo_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r <= 6'd48;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.num;
      rem_r <= '0;
      den_r <= req.den;
    end else begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo = quo_r;
endmodule
`default_nettype wire

// File: rtl/core/three_channel_kalman_dwell_estimator_core.sv
`default_nettype none
// Three-channel scalar Kalman dwell estimator. Each accepted request adds
// process noise to three variances, updates the estimate selected by its
// category (not for category none, nor for an occupancy request without a
// value), and produces one result with the three estimates, a dwell time
// in 1/256 hour (999 h saturated, forced when capacity is critical) and the
// request's timestamp. One request is processed at a time: a shared
// bit-serial divider computes the Kalman gain, the congestion overflow ratio
// and the dwell quotient. The gain division is skipped when no estimate is
// updated and the overflow division when occupancy does not exceed the jam
// threshold; a critical capacity ends the request right after the capacity
// check. A finished result waits in the output register and a new request
// is accepted as soon as that register is free or being taken.
// Configuration writes are taken in any cycle but must only occur while idle.
module three_channel_kalman_dwell_estimator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_category,
  input  wire logic [16:0] in_reliability,
  input  wire logic [16:0] in_severity,
  input  wire logic        in_has_value,
  input  wire logic [16:0] in_occupancy_value,
  input  wire logic signed [63:0] in_timestamp,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [16:0]      out_switch_estimate,
  output logic [16:0]      out_labor_estimate,
  output logic [16:0]      out_occupancy_estimate,
  output logic [17:0]      out_dwell_time,
  output logic             out_critical,
  output logic signed [63:0] out_report_time
);
  typedef enum logic [3:0] {
    S_IDLE, S_NOISE, S_KDIV, S_KWAIT, S_EST, S_VAR, S_CAP, S_CWAIT,
    S_CMUL, S_DDIV, S_DWAIT, S_DONE
  } state_t;

  state_t state_r;
  logic [15:0] noise_r, base_r, jam_r;
  logic [11:0] pen_r;
  logic [16:0] crit_thr_r;
  logic [16:0] est_r [3];
  logic [19:0] var_r [3];
  logic [1:0]  sel_r;
  logic        upd_r;
  logic [16:0] z_r, r_r;
  logic [16:0] k_r;
  logic [20:0] cong_r;
  logic [16:0] cap_r;
  logic signed [63:0] ts_r;
  tckde_pkg::div_req_t dreq;
  tckde_pkg::div_rsp_t drsp;

  tckde_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  function automatic logic [16:0] clamp1(input logic [16:0] v);
    return (v > tckde_pkg::ONE) ? tckde_pkg::ONE : v;
  endfunction

  logic accept;
  assign in_stall = out_valid && out_stall || (state_r != S_IDLE);
  assign accept = in_valid && !in_stall;

  // Datapath helpers for the selected channel.
  logic [16:0] e_cur, diffm;
  logic [19:0] v_cur;
  logic        up;
  logic [33:0] kprod;
  logic [16:0] e_new;
  logic [17:0] e_sum;
  logic [36:0] vprod;
  logic [20:0] v_rnd;
  logic [16:0] cap_c;
  logic [28:0] cprod;
  logic [36:0] dprod;
  logic [20:0] v_add [3];

  always_comb begin
    e_cur = clamp1(est_r[sel_r]);
    v_cur = var_r[sel_r];
    up = z_r >= e_cur;
    diffm = up ? z_r - e_cur : e_cur - z_r;
    kprod = k_r * diffm + {17'd0, tckde_pkg::HALF};
    e_sum = up ? {1'b0, e_cur} + {1'b0, kprod[32:16]}
               : {1'b0, e_cur} - {1'b0, kprod[32:16]};
    e_new = (e_sum > {1'b0, tckde_pkg::ONE}) ? tckde_pkg::ONE : e_sum[16:0];
    vprod = v_cur * (tckde_pkg::ONE - k_r) + {20'd0, tckde_pkg::HALF};
    v_rnd = vprod[36:16];
    cap_c = (est_r[0] < est_r[1]) ? est_r[0] : est_r[1];
    // The overflow ratio is at most one, so the scaled penalty fits 21 bits.
    cprod = drsp.quo[16:0] * pen_r;
    dprod = base_r * cong_r;
    for (int i = 0; i < 3; i++) v_add[i] = {1'b0, var_r[i]} + {5'd0, noise_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      noise_r <= 16'd262;
      base_r <= 16'd6144;
      jam_r <= 16'd55706;
      pen_r <= 12'd768;
      crit_thr_r <= 17'd13107;
      est_r[0] <= tckde_pkg::ONE;
      est_r[1] <= tckde_pkg::ONE;
      est_r[2] <= tckde_pkg::OCC_RESET;
      for (int i = 0; i < 3; i++) var_r[i] <= 20'd32768;
      out_dwell_time <= 18'd6144;
      out_report_time <= '0;
      dreq <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          tckde_pkg::REG_NOISE: noise_r <= cfg_data[15:0];
          tckde_pkg::REG_BASE:  base_r <= cfg_data[15:0];
          tckde_pkg::REG_JAM:   jam_r <= cfg_data[15:0];
          tckde_pkg::REG_PEN:   pen_r <= cfg_data[11:0];
          tckde_pkg::REG_CRIT:  crit_thr_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: if (accept) begin
          sel_r <= (in_category == tckde_pkg::CAT_OCC) ? 2'd2 :
                   (in_category == tckde_pkg::CAT_LABOR) ? 2'd1 : 2'd0;
          upd_r <= (in_category == tckde_pkg::CAT_MECH) ||
                   (in_category == tckde_pkg::CAT_LABOR) ||
                   (in_category == tckde_pkg::CAT_OCC && in_has_value);
          z_r <= (in_category == tckde_pkg::CAT_OCC) ? clamp1(in_occupancy_value)
                 : tckde_pkg::ONE - clamp1(in_severity);
          r_r <= tckde_pkg::ONE - clamp1(in_reliability) + tckde_pkg::EPS;
          ts_r <= in_timestamp;
          state_r <= S_NOISE;
        end
        S_NOISE: begin
          for (int i = 0; i < 3; i++)
            var_r[i] <= v_add[i][20] ? tckde_pkg::VAR_MAX : v_add[i][19:0];
          state_r <= upd_r ? S_KDIV : S_CAP;
        end
        S_KDIV: begin
          dreq.start <= 1'b1;
          dreq.num <= {12'd0, v_cur, 16'd0};
          dreq.den <= {1'b0, v_cur} + {4'd0, r_r};
          state_r <= S_KWAIT;
        end
        // The start pulse lasts one cycle; it is dropped on entry to each wait.
        S_KWAIT: begin
          dreq.start <= 1'b0;
          if (drsp.done) begin
            k_r <= drsp.quo[16:0];
            state_r <= S_EST;
          end
        end
        S_EST: begin
          est_r[sel_r] <= e_new;
          state_r <= S_VAR;
        end
        S_VAR: begin
          var_r[sel_r] <= (v_rnd > {1'b0, tckde_pkg::VAR_MAX}) ? tckde_pkg::VAR_MAX
                          : v_rnd[19:0];
          state_r <= S_CAP;
        end
        S_CAP: begin
          cap_r <= cap_c;
          if (cap_c < crit_thr_r) begin
            out_dwell_time <= tckde_pkg::DWELL_MAX;
            out_critical <= 1'b1;
            state_r <= S_DONE;
          end else begin
            out_critical <= 1'b0;
            cong_r <= {4'd0, tckde_pkg::ONE};
            if (est_r[2] > {1'b0, jam_r}) begin
              dreq.start <= 1'b1;
              dreq.num <= {15'd0, est_r[2] - {1'b0, jam_r}, 16'd0};
              dreq.den <= {4'd0, tckde_pkg::ONE - {1'b0, jam_r}};
              state_r <= S_CWAIT;
            end else state_r <= S_DDIV;
          end
        end
        S_CWAIT: begin
          dreq.start <= 1'b0;
          if (drsp.done) state_r <= S_CMUL;
        end
        S_CMUL: begin
          cong_r <= {4'd0, tckde_pkg::ONE} + cprod[28:8];
          state_r <= S_DDIV;
        end
        S_DDIV: begin
          dreq.start <= 1'b1;
          dreq.num <= {11'd0, dprod};
          dreq.den <= {4'd0, cap_r} + {4'd0, tckde_pkg::EPS};
          state_r <= S_DWAIT;
        end
        S_DWAIT: begin
          dreq.start <= 1'b0;
          if (drsp.done) begin
            out_dwell_time <= (drsp.quo > {30'd0, tckde_pkg::DWELL_MAX}) ?
                              tckde_pkg::DWELL_MAX : drsp.quo[17:0];
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          out_report_time <= ts_r;
          out_switch_estimate <= est_r[0];
          out_labor_estimate <= est_r[1];
          out_occupancy_estimate <= est_r[2];
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/tckde_checker.sv
`default_nettype none
module tckde_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [17:0] out_dwell_time,
  input wire logic out_critical
);
  a_dwell_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dwell_time <= 18'd255744) else $error("dwell over max");
  a_crit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_critical |-> out_dwell_time == 18'd255744)
    else $error("critical dwell");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("second request taken");
endmodule
bind three_channel_kalman_dwell_estimator_core tckde_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_dwell_time(out_dwell_time), .out_critical(out_critical));
`default_nettype wire
